FILE: rtl/mwm_pkg.sv
package mwm_pkg;

    // model count and fixed-point format
    localparam int MODEL_COUNT   = 4;
    localparam int FRACTION_BITS = 16;

    // field widths
    localparam int VALUE_W   = 32;
    localparam int WEIGHT_W  = 16;
    localparam int CFG_IDX_W = 8;

    // datapath widths: product, sums, quotient
    localparam int SUM_EXT = (MODEL_COUNT > 1) ? $clog2(MODEL_COUNT) : 0;
    localparam int PROD_W  = VALUE_W + WEIGHT_W;
    localparam int SUM_W   = PROD_W + SUM_EXT;
    localparam int DEN_W   = WEIGHT_W + SUM_EXT;
    localparam int Q_W     = VALUE_W;

    // missing code: -9999 in the fixed-point format, saturated to 32 bits
    localparam longint MISSING_MAG = longint'(9999) << FRACTION_BITS;
    localparam logic signed [VALUE_W-1:0] MISSING_CODE =
        (MISSING_MAG > 64'sd2147483648) ? 32'sh8000_0000 : VALUE_W'(-MISSING_MAG);

    // weight reset value, 1.0 in Q8.8
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

    typedef logic [MODEL_COUNT-1:0][VALUE_W-1:0]  t_sample_vec;
    typedef logic [MODEL_COUNT-1:0][WEIGHT_W-1:0] t_weight_vec;

    // control that travels with each item through the divider
    typedef struct packed {
        logic valid;
        logic neg;
        logic missing;
    } t_div_ctl;

endpackage

FILE: rtl/mwm_weight_regs.sv
module mwm_weight_regs
    import mwm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WEIGHT_W-1:0]  i_cfg_data,
    output logic                 o_cfg_ready,
    output t_weight_vec          o_weight
);

    t_weight_vec r_weight;

    // register writes are always taken; indexes past the models are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MODEL_COUNT; k++) begin
                r_weight[k] <= WEIGHT_RESET;
            end
        end else if (i_cfg_valid) begin
            for (int k = 0; k < MODEL_COUNT; k++) begin
                if (i_cfg_index == CFG_IDX_W'(k)) begin
                    r_weight[k] <= i_cfg_data;
                end
            end
        end
    end

    assign o_weight = r_weight;

    // a write to model zero lands in its register
    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && (i_cfg_index == '0) |=> r_weight[0] == $past(i_cfg_data))
        else $error("weight write to model zero lost");

endmodule

FILE: rtl/mwm_accum.sv
module mwm_accum
    import mwm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  t_sample_vec          i_sample,
    input  logic [MODEL_COUNT-1:0] i_present,
    input  t_weight_vec          i_weight,
    output t_div_ctl             o_ctl,
    output logic [DEN_W-1:0]     o_rem,
    output logic [Q_W-1:0]       o_low,
    output logic [DEN_W-1:0]     o_den
);

    logic                                   r_v1;
    logic [MODEL_COUNT-1:0][PROD_W-1:0]     r_prod;
    t_weight_vec                            r_wt;
    logic                                   r_v2;
    logic signed [SUM_W-1:0]                r_num;
    logic [DEN_W-1:0]                       r_den2;
    t_div_ctl                               r_ctl;
    logic [DEN_W-1:0]                       r_rem;
    logic [Q_W-1:0]                         r_low;
    logic [DEN_W-1:0]                       r_den;

    logic [MODEL_COUNT-1:0][PROD_W-1:0]     n_prod;
    t_weight_vec                            n_wt;
    logic signed [SUM_W-1:0]                n_num;
    logic [DEN_W-1:0]                       n_den2;
    logic [SUM_W-1:0]                       n_mag;
    logic                                   n_neg;

    // stage 1: per-model product, masked by the present flag
    always_comb begin
        logic signed [PROD_W:0] prod;
        for (int k = 0; k < MODEL_COUNT; k++) begin
            prod = $signed(i_sample[k]) * $signed({1'b0, i_weight[k]});
            n_prod[k] = i_present[k] ? prod[PROD_W-1:0] : '0;
            n_wt[k]   = i_present[k] ? i_weight[k] : '0;
        end
    end

    // stage 2: numerator and weight sums
    always_comb begin
        n_num  = '0;
        n_den2 = '0;
        for (int k = 0; k < MODEL_COUNT; k++) begin
            n_num  = n_num + SUM_W'($signed(r_prod[k]));
            n_den2 = n_den2 + DEN_W'(r_wt[k]);
        end
    end

    // stage 3: sign and magnitude for the unsigned divider
    always_comb begin
        n_neg = r_num[SUM_W-1];
        n_mag = n_neg ? SUM_W'(-r_num) : SUM_W'(r_num);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_ctl     <= '0;
        end else if (i_adv) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_ctl.valid   <= r_v2;
            r_ctl.neg     <= n_neg;
            r_ctl.missing <= (r_den2 == '0);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
            r_wt   <= n_wt;
            r_num  <= n_num;
            r_den2 <= n_den2;
            r_rem  <= n_mag[SUM_W-1:Q_W];
            r_low  <= n_mag[Q_W-1:0];
            r_den  <= r_den2;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_den = r_den;

    // an advancing item reaches the sum stage
    a_v1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && r_v1 |=> r_v2)
        else $error("item lost between product and sum stages");

    // quotient must fit: top of numerator below the weight sum
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid && !r_ctl.missing |-> r_rem < r_den)
        else $error("quotient overflow at divider entry");

endmodule

FILE: rtl/mwm_div_stage.sv
module mwm_div_stage
    import mwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_div_ctl         i_ctl,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [Q_W-1:0]   i_low,
    input  logic [Q_W-1:0]   i_quo,
    input  logic [DEN_W-1:0] i_den,
    output t_div_ctl         o_ctl,
    output logic [DEN_W-1:0] o_rem,
    output logic [Q_W-1:0]   o_low,
    output logic [Q_W-1:0]   o_quo,
    output logic [DEN_W-1:0] o_den
);

    t_div_ctl         r_ctl;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_low;
    logic [Q_W-1:0]   r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   n_trial;
    logic [DEN_W:0]   n_diff;
    logic             n_take;
    logic [DEN_W-1:0] n_rem;

    // one restoring step: shift in the next numerator bit, try subtract
    always_comb begin
        n_trial = {i_rem, i_low[Q_W-1]};
        n_diff  = n_trial - {1'b0, i_den};
        n_take  = (n_trial >= {1'b0, i_den});
        n_rem   = n_take ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem <= n_rem;
            r_low <= {i_low[Q_W-2:0], 1'b0};
            r_quo <= {i_quo[Q_W-2:0], n_take};
            r_den <= i_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_quo = r_quo;
    assign o_den = r_den;

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid && !r_ctl.missing |-> r_rem < r_den)
        else $error("divider remainder out of range");

endmodule

FILE: rtl/masked_weighted_mean_core.sv
// pipeline: 3 front stages, 32 divider stages at one quotient bit each, 1 output
//   register between input transfer and result
// throughput: one item per cycle; the whole pipeline holds while the output is stalled
// reset: synchronous active-low clears all valid bits and sets every weight to 1.0
module masked_weighted_mean_core
    import mwm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [VALUE_W-1:0]  i_sample_model0,
    input  logic                       i_present_model0,
    input  logic signed [VALUE_W-1:0]  i_sample_model1,
    input  logic                       i_present_model1,
    input  logic signed [VALUE_W-1:0]  i_sample_model2,
    input  logic                       i_present_model2,
    input  logic signed [VALUE_W-1:0]  i_sample_model3,
    input  logic                       i_present_model3,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [VALUE_W-1:0]  o_blended_value,
    output logic                       o_blend_missing,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [WEIGHT_W-1:0]        i_cfg_data
);

    logic                    adv;
    t_sample_vec             sample;
    logic [MODEL_COUNT-1:0]  present;
    t_weight_vec             weight;

    t_div_ctl                div_ctl [Q_W+1];
    logic [DEN_W-1:0]        div_rem [Q_W+1];
    logic [Q_W-1:0]          div_low [Q_W+1];
    logic [Q_W-1:0]          div_quo [Q_W+1];
    logic [DEN_W-1:0]        div_den [Q_W+1];

    logic                    r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                    r_out_missing;
    logic signed [VALUE_W-1:0] n_out_value;

    // whole pipeline moves unless a result sits stalled at the output
    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    // gather model fields
    assign sample  = {i_sample_model3, i_sample_model2, i_sample_model1, i_sample_model0};
    assign present = {i_present_model3, i_present_model2, i_present_model1, i_present_model0};

    // weight registers
    mwm_weight_regs u_weights (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_weight    (weight)
    );

    // products, sums, sign split
    mwm_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (i_valid),
        .i_sample  (sample),
        .i_present (present),
        .i_weight  (weight),
        .o_ctl     (div_ctl[0]),
        .o_rem     (div_rem[0]),
        .o_low     (div_low[0]),
        .o_den     (div_den[0])
    );

    assign div_quo[0] = '0;

    // divider chain, one quotient bit per stage
    for (genvar g = 0; g < Q_W; g++) begin : g_div
        mwm_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (div_ctl[g]),
            .i_rem   (div_rem[g]),
            .i_low   (div_low[g]),
            .i_quo   (div_quo[g]),
            .i_den   (div_den[g]),
            .o_ctl   (div_ctl[g+1]),
            .o_rem   (div_rem[g+1]),
            .o_low   (div_low[g+1]),
            .o_quo   (div_quo[g+1]),
            .o_den   (div_den[g+1])
        );
    end

    // restore sign or substitute missing code
    always_comb begin
        if (div_ctl[Q_W].missing) begin
            n_out_value = MISSING_CODE;
        end else if (div_ctl[Q_W].neg) begin
            n_out_value = VALUE_W'(-div_quo[Q_W]);
        end else begin
            n_out_value = VALUE_W'(div_quo[Q_W]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= div_ctl[Q_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_value   <= n_out_value;
            r_out_missing <= div_ctl[Q_W].missing;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_blended_value = r_out_value;
    assign o_blend_missing = r_out_missing;

    // missing results always carry the missing code
    a_missing_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_blend_missing |-> o_blended_value == MISSING_CODE)
        else $error("missing flag without missing code");

endmodule
